// ===== rtl/gda_pkg.sv =====
// Shared types, codes and calendar functions of the Gregorian date adder.
// No dependencies; used by gda_step_unit, gregorian_date_adder and the testbench.
package gda_pkg;

   // Sequencer modes
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_NORM   = 3'd1;
   localparam logic [2:0] MODE_DAYS   = 3'd2;
   localparam logic [2:0] MODE_MONTHS = 3'd3;
   localparam logic [2:0] MODE_YEARS  = 3'd4;
   localparam logic [2:0] MODE_DIRECT = 3'd5;
   localparam logic [2:0] MODE_CLAMP  = 3'd6;

   // Operation codes on req_tuser
   localparam logic [2:0] OP_DAYS        = 3'd0;
   localparam logic [2:0] OP_WEEKS       = 3'd1;
   localparam logic [2:0] OP_MONTHS      = 3'd2;
   localparam logic [2:0] OP_YEARS_STEP  = 3'd3;
   localparam logic [2:0] OP_YEARS_DIR   = 3'd4;
   localparam logic [2:0] OP_DECADE_STEP = 3'd5;
   localparam logic [2:0] OP_DECADE_DIR  = 3'd6;

   localparam int COUNT_W = 19;

   // Inverse of 25 modulo 2**16 and the largest multiple index of 25 below 2**16
   localparam logic [15:0] INV25     = 16'd23593;
   localparam logic [15:0] DIV25_MAX = 16'd2621;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [15:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [COUNT_W-1:0] count;
   } gda_state_type;

   function automatic logic leap(input logic [15:0] y);
      logic [31:0] prod;
      logic        div25;
      begin
         prod  = 32'(y) * 32'(INV25);
         div25 = (prod[15:0] <= DIV25_MAX);
         leap  = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
      logic [3:0] mi;
      begin
         mi = (m >= 4'd1 && m <= 4'd12) ? m - 4'd1 : 4'd0;
         if (m == 4'd2) begin
            month_len = lp ? 5'd29 : 5'd28;
         end else begin
            month_len = MONTH_LEN[mi];
         end
      end
   endfunction

endpackage

// ===== rtl/gda_step_unit.sv =====
// Shared step unit: one calendar step (day run, month, year, direct year add, clamp) per cycle.
// Depends on gda_pkg for the state struct, mode codes and calendar functions.
module gda_step_unit (
   input  logic [2:0]             mode,
   input  gda_pkg::gda_state_type cur,
   output gda_pkg::gda_state_type nxt
);

   logic [15:0] yq;
   logic        lp;
   logic [4:0]  len_cur;
   logic [4:0]  len_nm;
   logic [4:0]  feb;
   logic [8:0]  ylen;
   logic [5:0]  rem;
   logic [3:0]  nm;
   logic [15:0] ny;
   logic [4:0]  dfix;

   always_comb begin
      nm = (cur.month == 4'd12) ? 4'd1 : cur.month + 4'd1;
      ny = (cur.month == 4'd12) ? cur.year + 16'd1 : cur.year;
      yq = cur.year;
      case (mode)
         gda_pkg::MODE_MONTHS: begin
            if (cur.count >= gda_pkg::COUNT_W'(48)) begin
               yq = cur.year;
            end else if (cur.count >= gda_pkg::COUNT_W'(12)) begin
               yq = (cur.month >= 4'd2) ? cur.year + 16'd1 : cur.year;
            end else begin
               yq = ny;
            end
         end
         gda_pkg::MODE_YEARS: begin
            yq = cur.year + 16'd1;
         end
         default: begin
            yq = cur.year;
         end
      endcase
      lp      = gda_pkg::leap(yq);
      len_cur = gda_pkg::month_len(cur.month, lp);
      len_nm  = gda_pkg::month_len(nm, lp);
      feb     = lp ? 5'd29 : 5'd28;
      ylen    = lp ? 9'd366 : 9'd365;
      rem     = 6'(len_cur) - 6'(cur.day) + 6'd1;
      dfix    = (cur.day == 5'd0) ? 5'd1 : cur.day;
   end

   always_comb begin
      nxt = cur;
      case (mode)
         gda_pkg::MODE_NORM, gda_pkg::MODE_CLAMP: begin
            nxt.day = (dfix > len_cur) ? len_cur : dfix;
         end
         gda_pkg::MODE_DIRECT: begin
            nxt.year  = cur.year + cur.count[15:0];
            nxt.count = '0;
         end
         gda_pkg::MODE_DAYS: begin
            if (cur.count != '0) begin
               if (cur.month == 4'd1 && cur.day == 5'd1 &&
                   cur.count >= gda_pkg::COUNT_W'(ylen)) begin
                  nxt.year  = cur.year + 16'd1;
                  nxt.count = cur.count - gda_pkg::COUNT_W'(ylen);
               end else if (cur.count >= gda_pkg::COUNT_W'(rem)) begin
                  nxt.day   = 5'd1;
                  nxt.month = nm;
                  nxt.year  = ny;
                  nxt.count = cur.count - gda_pkg::COUNT_W'(rem);
               end else begin
                  nxt.day   = cur.day + cur.count[4:0];
                  nxt.count = '0;
               end
            end
         end
         gda_pkg::MODE_MONTHS: begin
            if (cur.count >= gda_pkg::COUNT_W'(48)) begin
               nxt.year  = cur.year + 16'd4;
               nxt.day   = (cur.day > 5'd28) ? 5'd28 : cur.day;
               nxt.count = cur.count - gda_pkg::COUNT_W'(48);
            end else if (cur.count >= gda_pkg::COUNT_W'(12)) begin
               nxt.year  = cur.year + 16'd1;
               nxt.day   = (cur.day > feb) ? feb : cur.day;
               nxt.count = cur.count - gda_pkg::COUNT_W'(12);
            end else if (cur.count != '0) begin
               nxt.month = nm;
               nxt.year  = ny;
               nxt.day   = (cur.day > len_nm) ? len_nm : cur.day;
               nxt.count = cur.count - gda_pkg::COUNT_W'(1);
            end
         end
         gda_pkg::MODE_YEARS: begin
            if (cur.count > gda_pkg::COUNT_W'(4)) begin
               nxt.year  = cur.year + cur.count[15:0] - 16'd4;
               nxt.count = gda_pkg::COUNT_W'(4);
            end else if (cur.count != '0) begin
               nxt.year  = cur.year + 16'd1;
               nxt.day   = (cur.day > len_cur) ? len_cur : cur.day;
               nxt.count = cur.count - gda_pkg::COUNT_W'(1);
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== rtl/gregorian_date_adder.sv =====
// Gregorian date adder top level: handshake, sequencer and date registers.
// Depends on gda_pkg and gda_step_unit.
//
//   channel   direction  tdata fields (low bit up)              tuser
//   req_      in         year, month, day, amount               operation
//   rsp_      out        new_year, new_month, new_day           -
//
// One item at a time; req_tready is high only while the sequencer is idle.
// A month out of range finishes at once; any other item first takes a
// normalizing pass, then an unused code finishes, direct years or decades
// take a direct add and a clamp, and the rest step until the count is spent;
// one pass of the shared step unit per cycle, req_tready rises again with the result.
// Reset clears the sequencer and the output valid; the result register holds
// a finished item while rsp_tready is low and the sequencer waits on it.
module gregorian_date_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // year[15:0], month[19:16], day[24:20], amount[40:25]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // new_year[15:0], new_month[19:16], new_day[24:20]
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic                   state_ff, state_in;
   logic [2:0]             mode_ff, mode_in;
   logic [2:0]             after_ff, after_in;
   gda_pkg::gda_state_type cur_ff, cur_in;
   gda_pkg::gda_state_type nxt;
   logic                   rsp_valid_ff, rsp_valid_in;
   gda_pkg::gda_state_type res_ff, res_in;

   logic [15:0] in_year;
   logic [3:0]  in_month;
   logic [4:0]  in_day;
   logic [15:0] in_amount;
   logic [19:0] amt10;
   logic [18:0] amt7;
   logic        accept;
   logic        finish;
   logic        can_finish;

   gda_step_unit u_step (
      .mode (mode_ff),
      .cur  (cur_ff),
      .nxt  (nxt)
   );

   assign in_year   = req_tdata[15:0];
   assign in_month  = req_tdata[19:16];
   assign in_day    = req_tdata[24:20];
   assign in_amount = req_tdata[40:25];
   assign amt10     = {1'b0, in_amount, 3'b000} + {3'b000, in_amount, 1'b0};
   assign amt7      = {in_amount, 3'b000} - {3'b000, in_amount};

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign can_finish = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      after_in     = after_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      finish       = 1'b0;

      if (state_ff == ST_IDLE) begin
         if (accept) begin
            state_in     = ST_BUSY;
            cur_in.year  = in_year;
            cur_in.month = in_month;
            cur_in.day   = in_day;
            cur_in.count = gda_pkg::COUNT_W'(in_amount);
            mode_in      = (in_month >= 4'd1 && in_month <= 4'd12) ?
                           gda_pkg::MODE_NORM : gda_pkg::MODE_NONE;
            case (req_tuser)
               gda_pkg::OP_DAYS: begin
                  after_in = gda_pkg::MODE_DAYS;
               end
               gda_pkg::OP_WEEKS: begin
                  after_in     = gda_pkg::MODE_DAYS;
                  cur_in.count = amt7;
               end
               gda_pkg::OP_MONTHS: begin
                  after_in = gda_pkg::MODE_MONTHS;
               end
               gda_pkg::OP_YEARS_STEP: begin
                  after_in = gda_pkg::MODE_YEARS;
               end
               gda_pkg::OP_YEARS_DIR: begin
                  after_in = gda_pkg::MODE_DIRECT;
               end
               gda_pkg::OP_DECADE_STEP: begin
                  after_in     = gda_pkg::MODE_YEARS;
                  cur_in.count = (amt10 > 20'd65535) ? gda_pkg::COUNT_W'(65535) :
                                 gda_pkg::COUNT_W'(amt10);
               end
               gda_pkg::OP_DECADE_DIR: begin
                  after_in     = gda_pkg::MODE_DIRECT;
                  cur_in.count = gda_pkg::COUNT_W'(amt10[15:0]);
               end
               default: begin
                  after_in = gda_pkg::MODE_NONE;
               end
            endcase
         end
      end else begin
         case (mode_ff)
            gda_pkg::MODE_NORM: begin
               cur_in  = nxt;
               mode_in = after_ff;
            end
            gda_pkg::MODE_DIRECT: begin
               cur_in  = nxt;
               mode_in = gda_pkg::MODE_CLAMP;
            end
            gda_pkg::MODE_DAYS, gda_pkg::MODE_MONTHS, gda_pkg::MODE_YEARS: begin
               if (cur_ff.count != '0) begin
                  cur_in = nxt;
               end else begin
                  finish = 1'b1;
               end
            end
            default: begin
               finish = 1'b1;
            end
         endcase
         // hold the last step until the result register is free
         if (finish) begin
            cur_in = cur_ff;
            if (can_finish) begin
               res_in       = nxt;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= gda_pkg::MODE_NONE;
         after_ff     <= gda_pkg::MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         after_ff     <= after_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.day, res_ff.month, res_ff.year};

endmodule

// ===== tb/sv/gda_date_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the Gregorian date adder: watches both stream channels,
// predicts each result from the accepted item and compares field by field.
// Depends on gda_pkg for the operation codes.
module gda_date_checker
   import gda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // year[15:0], month[19:16], day[24:20], amount[40:25]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // new_year[15:0], new_month[19:16], new_day[24:20]
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } calendar_date_type;

   calendar_date_type pending_dates[$];
   int                errors = 0;

   function automatic bit is_leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      case (m)
         2: begin
            return is_leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic calendar_date_type advance_date(input calendar_date_type start,
                                                      input logic [2:0] op,
                                                      input logic [15:0] amount);
      int y;
      int m;
      int d;
      int steps;
      int len;
      int ylen;
      int total;
      calendar_date_type res;
      y = int'(start.year);
      m = int'(start.month);
      d = int'(start.day);
      if (m >= 1 && m <= 12) begin
         if (d == 0) d = 1;
         len = days_in_month(m, y);
         if (d > len) d = len;
         case (op)
            OP_DAYS, OP_WEEKS: begin
               steps = (op == OP_WEEKS) ? int'(amount) * 7 : int'(amount);
               while (steps > 0) begin
                  ylen = is_leap_year(y) ? 366 : 365;
                  if (m == 1 && d == 1 && steps >= ylen) begin
                     steps = steps - ylen;
                     y = (y + 1) % 65536;
                  end else begin
                     len = days_in_month(m, y);
                     if (steps <= len - d) begin
                        d = d + steps;
                        steps = 0;
                     end else begin
                        steps = steps - (len - d + 1);
                        d = 1;
                        if (m == 12) begin
                           m = 1;
                           y = (y + 1) % 65536;
                        end else begin
                           m = m + 1;
                        end
                     end
                  end
               end
            end
            OP_MONTHS: begin
               steps = int'(amount);
               // a day above 28 may still be clamped; step until it cannot be
               while (steps > 0 && d > 28) begin
                  if (m == 12) begin
                     m = 1;
                     y = (y + 1) % 65536;
                  end else begin
                     m = m + 1;
                  end
                  len = days_in_month(m, y);
                  if (d > len) d = len;
                  steps = steps - 1;
               end
               total = (m - 1) + steps;
               y = (y + total / 12) % 65536;
               m = total % 12 + 1;
            end
            OP_YEARS_STEP, OP_DECADE_STEP: begin
               if (op == OP_DECADE_STEP) begin
                  steps = int'(amount) * 10;
                  if (steps > 65535) steps = 65535;
               end else begin
                  steps = int'(amount);
               end
               // only February 29 can be clamped while the month stays fixed
               while (steps > 0 && m == 2 && d == 29) begin
                  y = (y + 1) % 65536;
                  if (!is_leap_year(y)) d = 28;
                  steps = steps - 1;
               end
               y = (y + steps) % 65536;
            end
            OP_YEARS_DIR, OP_DECADE_DIR: begin
               steps = (op == OP_DECADE_DIR) ? int'(amount) * 10 : int'(amount);
               y = (y + steps) % 65536;
               len = days_in_month(m, y);
               if (d > len) d = len;
            end
            default: begin
            end
         endcase
      end
      res.year  = 16'(y);
      res.month = 4'(m);
      res.day   = 5'(d);
      return res;
   endfunction

   always @(posedge clock) begin
      calendar_date_type got;
      calendar_date_type want;
      calendar_date_type start;
      if (reset) begin
         pending_dates.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.year  = rsp_tdata[15:0];
            got.month = rsp_tdata[19:16];
            got.day   = rsp_tdata[24:20];
            if (pending_dates.size() == 0) begin
               $error("result with no item outstanding: year %0d month %0d day %0d",
                      got.year, got.month, got.day);
               errors++;
            end else begin
               want = pending_dates.pop_front();
               if (got.year !== want.year) begin
                  $error("new_year: expected %0d, actual %0d", want.year, got.year);
                  errors++;
               end
               if (got.month !== want.month) begin
                  $error("new_month: expected %0d, actual %0d", want.month, got.month);
                  errors++;
               end
               if (got.day !== want.day) begin
                  $error("new_day: expected %0d, actual %0d", want.day, got.day);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            start.year  = req_tdata[15:0];
            start.month = req_tdata[19:16];
            start.day   = req_tdata[24:20];
            pending_dates.push_back(advance_date(start, req_tuser, req_tdata[40:25]));
         end
      end
      mismatch_count <= errors;
      pending_count  <= pending_dates.size();
   end

endmodule

// ===== tb/sv/tb_gregorian_date_adder.sv =====
`timescale 1ns / 100ps
// Top of the Gregorian date adder testbench: clock, reset, item stimulus,
// result-side backpressure, watchdog and verdict.
// Depends on gda_pkg, gregorian_date_adder and gda_date_checker.
module tb_gregorian_date_adder;
   import gda_pkg::*;

   localparam logic [2:0] OP_UNUSED      = 3'd7;
   localparam int         RANDOM_ITEMS   = 1600;
   localparam int         CALM_ITEMS     = 200;
   localparam int         LONG_HOLD      = 300;
   localparam int         DRAIN_CYCLES   = 1400;
   localparam int         WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // year[15:0], month[19:16], day[24:20], amount[40:25]
   logic [2:0]  req_tuser;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // new_year[15:0], new_month[19:16], new_day[24:20]

   int mismatch_count;
   int pending_count;
   int quiet_cycles = 0;
   bit sender_gaps = 1'b1;
   bit ready_gaps = 1'b1;
   bit long_hold_due = 1'b0;

   gregorian_date_adder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gda_date_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic offer_item(input logic [15:0] year, input logic [3:0] month,
                             input logic [4:0] day, input logic [2:0] op,
                             input logic [15:0] amount);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, amount, day, month, year};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // result side: random ready stretches, short stalls and one long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            hold_left = LONG_HOLD;
         end else if (ready_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b1;
            hold_left = $urandom_range(0, 15);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int          r;
      logic [15:0] yr;
      logic [15:0] amt;
      logic [3:0]  mo;
      logic [4:0]  dy;
      logic [2:0]  op;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_DAYS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_item(16'd0,     4'd1,  5'd1,  OP_DAYS,        16'd0);
      offer_item(16'd65535, 4'd12, 5'd31, OP_DAYS,        16'd1);
      offer_item(16'd2024,  4'd2,  5'd28, OP_DAYS,        16'd1);
      offer_item(16'd1900,  4'd2,  5'd28, OP_DAYS,        16'd1);
      offer_item(16'd2000,  4'd2,  5'd28, OP_DAYS,        16'd1);
      offer_item(16'd2024,  4'd1,  5'd1,  OP_DAYS,        16'd65535);
      offer_item(16'd2024,  4'd3,  5'd15, OP_WEEKS,       16'd65535);
      offer_item(16'd2024,  4'd1,  5'd31, OP_MONTHS,      16'd1);
      offer_item(16'd2023,  4'd1,  5'd31, OP_MONTHS,      16'd13);
      offer_item(16'd65535, 4'd12, 5'd15, OP_MONTHS,      16'd65535);
      offer_item(16'd2024,  4'd2,  5'd29, OP_YEARS_STEP,  16'd4);
      offer_item(16'd2024,  4'd2,  5'd29, OP_YEARS_DIR,   16'd4);
      offer_item(16'd2024,  4'd2,  5'd29, OP_YEARS_DIR,   16'd65535);
      offer_item(16'd2024,  4'd2,  5'd29, OP_DECADE_STEP, 16'd65535);
      offer_item(16'd2000,  4'd2,  5'd29, OP_DECADE_STEP, 16'd40);
      offer_item(16'd2000,  4'd2,  5'd29, OP_DECADE_DIR,  16'd40);
      offer_item(16'd65535, 4'd6,  5'd30, OP_DECADE_DIR,  16'd65535);
      offer_item(16'd2024,  4'd0,  5'd0,  OP_DAYS,        16'd5);
      offer_item(16'd2024,  4'd13, 5'd31, OP_MONTHS,      16'd3);
      offer_item(16'd1234,  4'd15, 5'd17, OP_WEEKS,       16'd9);
      offer_item(16'd2024,  4'd3,  5'd0,  OP_DAYS,        16'd1);
      offer_item(16'd2023,  4'd2,  5'd31, OP_YEARS_DIR,   16'd1);
      offer_item(16'd2023,  4'd4,  5'd31, OP_DAYS,        16'd0);
      offer_item(16'd2023,  4'd2,  5'd30, OP_UNUSED,      16'd1234);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) long_hold_due = 1'b1;
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            sender_gaps = 1'b0;
            ready_gaps  = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (r < 50) begin
            yr = 16'($urandom);
         end else if (r < 80) begin
            yr = 16'($urandom_range(1583, 2500));
         end else if (r < 90) begin
            yr = 16'($urandom_range(65526, 65535));
         end else begin
            yr = 16'($urandom_range(0, 15));
         end
         mo = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 12));
         r = $urandom_range(0, 99);
         if (r < 5) begin
            dy = 5'($urandom_range(0, 31));
         end else if (r < 75) begin
            dy = 5'($urandom_range(1, 28));
         end else begin
            dy = 5'($urandom_range(29, 31));
         end
         op = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
         r = $urandom_range(0, 99);
         if (r < 50) begin
            amt = 16'($urandom_range(0, 40));
         end else if (r < 85) begin
            amt = 16'($urandom_range(0, 1000));
         end else if (r < 95) begin
            amt = 16'($urandom);
         end else begin
            amt = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd65535;
         end
         offer_item(yr, mo, dy, op, amt);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
